// ===== hw/rtl/meter_frame_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on nothing; users supply clock and reset signals by those names.
`ifndef METER_FRAME_DEFRAMER_MACROS_SVH
`define METER_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define MFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mfd_pkg.sv =====
// Types and constants of the meter frame deframer.
// No dependencies; imported by meter_frame_deframer, mfd_dp, mfd_ctrl and the testbench.
package mfd_pkg;

   localparam logic [7:0] START_MARK = 8'h68;
   localparam logic [7:0] END_MARK   = 8'h16;
   localparam int LEN_W = 16;   // frame length field
   localparam int OFS_W = 17;   // byte offset within a candidate frame

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_READ = 2'd1,
      CMD_POLL = 2'd2,
      CMD_NOP  = 2'd3
   } req_cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  rx_byte;
      logic [11:0] read_index;
   } mfd_req_type;

   typedef struct packed {
      logic        frame_valid;
      logic [7:0]  frame_seq;
      logic [5:0]  func_code;
      logic        abnormal;
      logic [12:0] payload_len;
      logic [7:0]  read_data;
      logic        overflow;
   } mfd_rsp_type;

   typedef enum logic [1:0] {
      SM_HDR,
      SM_BODY,
      SM_COPY
   } scan_mode_type;

   typedef enum logic [1:0] {
      RK_NONE,
      RK_FRAME,
      RK_READ
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_HDR,
      ST_EVAL_HDR,
      ST_BODY,
      ST_EVAL_BODY,
      ST_COPY,
      ST_ACCEPT,
      ST_DROP,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic          push;
      logic          rd_issue;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          drop_one;
      logic          take_frame;
      logic          load_rsp;
      rsp_kind_type  rsp_kind;
   } mfd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic too_short;
      logic scan_done;
      logic hdr_bad;
      logic frame_short;
      logic body_bad;
   } mfd_status_type;

endpackage

// ===== hw/rtl/meter_frame_deframer.sv =====
// Meter frame deframer: received bytes go into a ring buffer that is hunted
// for start/length/checksum framed packets. A request pushes a byte and hunts
// (cmd 0), reads one byte of the last good payload (cmd 1), re-hunts the buffer
// (cmd 2) or does nothing (cmd 3). Every request gives exactly one response.
// A payload read goes through ST_READ to the response register; a push or
// poll that finds too few bytes goes through ST_CHECK. Each candidate start
// gets a header scan of HDR_LEN bytes (HDR_LEN = ADDR_BYTES+7) and a check,
// plus a drop step when it is dropped; a full candidate adds a checksum scan
// of len+2 bytes, a payload copy of len bytes and an accept step.
// The ring has a single read port, read one byte per cycle while a scan runs.
// One request is in work at a time; req_stall is high until it finishes.
// The response register holds a finished result while rsp_stall is high;
// the next request is taken meanwhile and waits in its last step.
// Reset empties the ring, clears the overflow flag and the stored payload
// length; memory contents need no clearing pass.
// Depends on mfd_pkg, mfd_ctrl, mfd_dp, mfd_ram and the macros header.
module meter_frame_deframer import mfd_pkg::*; #(
   parameter int ADDR_BYTES  = 4,
   parameter int MAX_PAYLOAD = 4096,
   parameter int RING_DEPTH  = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mfd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mfd_rsp_type rsp_data
);
   mfd_cmd_type    cmd;
   mfd_status_type status;

   mfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_data.cmd),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   mfd_dp #(
      .ADDR_BYTES  (ADDR_BYTES),
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .RING_DEPTH  (RING_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

`include "meter_frame_deframer_macros.svh"

   // one request in work at a time
   `MFD_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall,
                    "request not held off")
   // reported frame length stays within limit
   `MFD_ASSERT_SAME(a_len_bound, rsp_valid && rsp_data.frame_valid,
                    rsp_data.payload_len <= 13'(MAX_PAYLOAD), "frame length above limit")
   // overflow flag is sticky
   `MFD_ASSERT_NEXT(a_ovf_sticky, rsp_valid && rsp_data.overflow,
                    !rsp_valid || rsp_data.overflow, "overflow flag cleared")
endmodule

// ===== hw/rtl/mfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/mfd_dp.sv =====
// Deframer datapath: ring buffer, scan engine, header capture, payload store.
// Depends on mfd_pkg and mfd_ram.
module mfd_dp import mfd_pkg::*; #(
   parameter int ADDR_BYTES  = 4,
   parameter int MAX_PAYLOAD = 4096,
   parameter int RING_DEPTH  = 8192
) (
   input  logic           clock,
   input  logic           reset,
   input  mfd_req_type    req_data,
   input  mfd_cmd_type    cmd,
   output mfd_status_type status,
   output mfd_rsp_type    rsp_data
);
   localparam int HDR_LEN = ADDR_BYTES + 7;
   localparam int RW  = $clog2(RING_DEPTH);
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int PW  = $clog2(MAX_PAYLOAD);
   localparam int PCW = $clog2(MAX_PAYLOAD + 1);
   localparam int SW  = ((RW > OFS_W) ? RW : OFS_W) + 1;
   localparam int IW  = 13;

   // ring state
   logic [RW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           ovf_ff, ovf_in;
   logic [PCW-1:0] pcount_ff, pcount_in;

   // scan engine
   logic [OFS_W-1:0] pos_ff, pos_in, end_ff, end_in, tag_ff, tag_in;
   logic             busy_ff, busy_in, tag_vld_ff, tag_vld_in;
   scan_mode_type    mode_ff, mode_in;
   logic [7:0]       sum_ff, sum_in;

   // captured frame bytes
   logic [7:0] b0_ff, b0_in, b2_ff, b2_in, b3_ff, b3_in, b6_ff, b6_in;
   logic [7:0] seq_ff, seq_in, mark_ff, mark_in, ctrl_ff, ctrl_in;
   logic [7:0] len_lo_ff, len_lo_in, len_hi_ff, len_hi_in;
   logic [7:0] chk_ff, chk_in, endb_ff, endb_in;
   logic       rd_ok_ff, rd_ok_in;
   mfd_rsp_type rsp_ff, rsp_in;

   logic [LEN_W-1:0] len;
   logic [OFS_W-1:0] total, scan_beg, scan_end, body_sum_end;
   logic [SW-1:0]    tail_sum, rd_sum, adv_sum, adv;
   logic [RW-1:0]    ring_wr_addr, ring_rd_addr;
   logic [7:0]       ring_q, pay_q;
   logic             full, pay_we;
   logic [PW-1:0]    pay_wr_addr;
   logic [OFS_W-1:0] pay_ofs;
   logic [IW-1:0]    idx_ext;

   assign len          = {len_hi_ff, len_lo_ff};
   assign total        = OFS_W'(HDR_LEN) + OFS_W'(len) + OFS_W'(2);
   assign body_sum_end = OFS_W'(HDR_LEN) + OFS_W'(len);
   assign full         = (count_ff == CW'(RING_DEPTH));

   // ring addresses: offsets always stay below twice the depth
   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (full) begin
         ring_wr_addr = head_ff;
      end else if (tail_sum >= SW'(RING_DEPTH)) begin
         ring_wr_addr = RW'(tail_sum - SW'(RING_DEPTH));
      end else begin
         ring_wr_addr = RW'(tail_sum);
      end
      rd_sum = SW'(head_ff) + SW'(pos_ff);
      if (rd_sum >= SW'(RING_DEPTH)) begin
         ring_rd_addr = RW'(rd_sum - SW'(RING_DEPTH));
      end else begin
         ring_rd_addr = RW'(rd_sum);
      end
      adv     = cmd.take_frame ? SW'(total) : SW'(1);
      adv_sum = SW'(head_ff) + adv;
      if (adv_sum >= SW'(RING_DEPTH)) begin
         adv_sum = adv_sum - SW'(RING_DEPTH);
      end
   end

   // status to the controller
   always_comb begin
      status.too_short   = (count_ff < CW'(HDR_LEN));
      status.scan_done   = !busy_ff && !tag_vld_ff;
      status.hdr_bad     = (b0_ff != START_MARK) || (mark_ff != START_MARK) ||
                           (len > LEN_W'(MAX_PAYLOAD)) ||
                           ((b2_ff == 8'd1) && (b3_ff == 8'd0) && (b6_ff == END_MARK));
      status.frame_short = (SW'(count_ff) < SW'(total));
      status.body_bad    = (chk_ff != sum_ff) || (endb_ff != END_MARK) || ctrl_ff[7];
   end

   // scan window per mode
   always_comb begin
      unique case (cmd.scan_mode)
         SM_HDR: begin
            scan_beg = '0;
            scan_end = OFS_W'(HDR_LEN);
         end
         SM_BODY: begin
            scan_beg = OFS_W'(HDR_LEN);
            scan_end = total;
         end
         SM_COPY: begin
            scan_beg = OFS_W'(HDR_LEN);
            scan_end = body_sum_end;
         end
         default: begin
            scan_beg = '0;
            scan_end = '0;
         end
      endcase
   end

   // payload copy port
   assign pay_ofs     = tag_ff - OFS_W'(HDR_LEN);
   assign pay_wr_addr = pay_ofs[PW-1:0];
   assign pay_we      = tag_vld_ff && (mode_ff == SM_COPY);
   assign idx_ext     = IW'(req_data.read_index);

   // next state of the datapath
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      pcount_in  = pcount_ff;
      pos_in     = pos_ff;
      end_in     = end_ff;
      busy_in    = busy_ff;
      mode_in    = mode_ff;
      tag_in     = pos_ff;
      tag_vld_in = busy_ff;
      sum_in     = sum_ff;
      b0_in      = b0_ff;
      b2_in      = b2_ff;
      b3_in      = b3_ff;
      b6_in      = b6_ff;
      seq_in     = seq_ff;
      mark_in    = mark_ff;
      ctrl_in    = ctrl_ff;
      len_lo_in  = len_lo_ff;
      len_hi_in  = len_hi_ff;
      chk_in     = chk_ff;
      endb_in    = endb_ff;
      rd_ok_in   = rd_ok_ff;
      rsp_in     = rsp_ff;

      // push: drop the oldest byte when full
      if (cmd.push) begin
         if (full) begin
            head_in = adv_sum[RW-1:0];
            ovf_in  = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.drop_one) begin
         head_in  = adv_sum[RW-1:0];
         count_in = count_ff - CW'(1);
      end
      if (cmd.take_frame) begin
         head_in   = adv_sum[RW-1:0];
         count_in  = CW'(SW'(count_ff) - SW'(total));
         pcount_in = PCW'(len);
      end

      // payload read range check
      if (cmd.rd_issue) begin
         rd_ok_in = (idx_ext < IW'(pcount_ff)) && (idx_ext < IW'(MAX_PAYLOAD));
      end

      // read issue, one byte per cycle
      if (busy_ff) begin
         pos_in  = pos_ff + OFS_W'(1);
         busy_in = (pos_ff + OFS_W'(1)) < end_ff;
      end

      // consume returned ring data
      if (tag_vld_ff) begin
         if (mode_ff == SM_HDR) begin
            sum_in = sum_ff + ring_q;
            if (tag_ff == OFS_W'(0)) b0_in = ring_q;
            if (tag_ff == OFS_W'(2)) b2_in = ring_q;
            if (tag_ff == OFS_W'(3)) b3_in = ring_q;
            if (tag_ff == OFS_W'(6)) b6_in = ring_q;
            if (tag_ff == OFS_W'(ADDR_BYTES + 1)) seq_in    = ring_q;
            if (tag_ff == OFS_W'(ADDR_BYTES + 3)) mark_in   = ring_q;
            if (tag_ff == OFS_W'(ADDR_BYTES + 4)) ctrl_in   = ring_q;
            if (tag_ff == OFS_W'(ADDR_BYTES + 5)) len_lo_in = ring_q;
            if (tag_ff == OFS_W'(ADDR_BYTES + 6)) len_hi_in = ring_q;
         end else if (mode_ff == SM_BODY) begin
            if (tag_ff < body_sum_end) sum_in = sum_ff + ring_q;
            if (tag_ff == body_sum_end) chk_in = ring_q;
            if (tag_ff == body_sum_end + OFS_W'(1)) endb_in = ring_q;
         end
      end

      // start a scan
      if (cmd.scan_start) begin
         pos_in  = scan_beg;
         end_in  = scan_end;
         busy_in = scan_beg < scan_end;
         mode_in = cmd.scan_mode;
         if (cmd.scan_mode == SM_HDR) sum_in = '0;
      end

      // result register
      if (cmd.load_rsp) begin
         rsp_in          = '0;
         rsp_in.overflow = ovf_ff;
         unique case (cmd.rsp_kind)
            RK_FRAME: begin
               rsp_in.frame_valid = 1'b1;
               rsp_in.frame_seq   = seq_ff;
               rsp_in.func_code   = ctrl_ff[5:0];
               rsp_in.abnormal    = ctrl_ff[6];
               rsp_in.payload_len = 13'(len);
            end
            RK_READ: begin
               rsp_in.read_data = rd_ok_ff ? pay_q : 8'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         pcount_ff  <= '0;
         busy_ff    <= 1'b0;
         tag_vld_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         ovf_ff     <= ovf_in;
         pcount_ff  <= pcount_in;
         busy_ff    <= busy_in;
         tag_vld_ff <= tag_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      end_ff    <= end_in;
      tag_ff    <= tag_in;
      mode_ff   <= mode_in;
      sum_ff    <= sum_in;
      b0_ff     <= b0_in;
      b2_ff     <= b2_in;
      b3_ff     <= b3_in;
      b6_ff     <= b6_in;
      seq_ff    <= seq_in;
      mark_ff   <= mark_in;
      ctrl_ff   <= ctrl_in;
      len_lo_ff <= len_lo_in;
      len_hi_ff <= len_hi_in;
      chk_ff    <= chk_in;
      endb_ff   <= endb_in;
      rd_ok_ff  <= rd_ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // ring buffer
   mfd_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (ring_wr_addr),
      .wr_data (req_data.rx_byte),
      .rd_en   (busy_ff),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_q)
   );

   // payload of the last good frame
   mfd_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_payload (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (pay_wr_addr),
      .wr_data (ring_q),
      .rd_en   (cmd.rd_issue),
      .rd_addr (req_data.read_index[PW-1:0]),
      .rd_data (pay_q)
   );
endmodule

// ===== hw/rtl/mfd_ctrl.sv =====
// Deframer controller: request sequencing, frame hunt steps, result hand-off.
// Depends on mfd_pkg.
module mfd_ctrl import mfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_cmd,
   input  mfd_status_type status,
   output mfd_cmd_type    cmd,
   output logic           rsp_valid,
   input  logic           rsp_stall
);
   state_type    state_ff, state_in;
   rsp_kind_type kind_ff, kind_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= RK_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      cmd.scan_mode = SM_HDR;
      cmd.rsp_kind  = kind_ff;
      req_stall = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd_type'(req_cmd))
                  CMD_PUSH: begin
                     cmd.push = 1'b1;
                     kind_in  = RK_NONE;
                     state_in = ST_CHECK;
                  end
                  CMD_POLL: begin
                     kind_in  = RK_NONE;
                     state_in = ST_CHECK;
                  end
                  CMD_READ: begin
                     cmd.rd_issue = 1'b1;
                     kind_in  = RK_READ;
                     state_in = ST_READ;
                  end
                  default: begin
                     kind_in  = RK_NONE;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_CHECK: begin
            if (status.too_short) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SM_HDR;
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (status.scan_done) state_in = ST_EVAL_HDR;
         end
         ST_EVAL_HDR: begin
            if (status.hdr_bad) begin
               state_in = ST_DROP;
            end else if (status.frame_short) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SM_BODY;
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            if (status.scan_done) state_in = ST_EVAL_BODY;
         end
         ST_EVAL_BODY: begin
            if (status.body_bad) begin
               state_in = ST_DROP;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SM_COPY;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (status.scan_done) state_in = ST_ACCEPT;
         end
         ST_ACCEPT: begin
            cmd.take_frame = 1'b1;
            kind_in  = RK_FRAME;
            state_in = ST_DONE;
         end
         ST_DROP: begin
            cmd.drop_one = 1'b1;
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== test/meter_frame_deframer_tb.sv =====
// Testbench of meter_frame_deframer: byte, read, poll and unused-command requests
// with a frame hunting predictor and an in-order scoreboard of responses.
// Depends on mfd_pkg and the meter_frame_deframer RTL.
module meter_frame_deframer_tb;
   import mfd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_BYTES  = 4;
   localparam int MAX_PAYLOAD = 4096;
   localparam int RING_DEPTH  = 8192;
   localparam int HDR_LEN     = ADDR_BYTES + 7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mfd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mfd_rsp_type rsp_data;

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   meter_frame_deframer #(
      .ADDR_BYTES(ADDR_BYTES), .MAX_PAYLOAD(MAX_PAYLOAD), .RING_DEPTH(RING_DEPTH)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Predictor of the deframer plus the queue of expected responses
   class deframer_board;
      logic [7:0]  ring[RING_DEPTH];
      int          head, count;
      logic [7:0]  payload[MAX_PAYLOAD];
      int          payload_count;
      bit          ovf;
      mfd_rsp_type pending[$];

      function new();
         head = 0; count = 0; payload_count = 0; ovf = 0;
      endfunction

      function logic [7:0] at(int k);
         return ring[(head + k) % RING_DEPTH];
      endfunction

      function void drop(int n);
         if (n > count) n = count;
         head = (head + n) % RING_DEPTH;
         count -= n;
      endfunction

      function void hunt(ref mfd_rsp_type r);
         int len, sum;
         logic [7:0] ctrl;
         forever begin
            if (count < HDR_LEN) return;
            if (at(0) != START_MARK || at(ADDR_BYTES + 3) != START_MARK) begin
               drop(1); continue;
            end
            len = {at(ADDR_BYTES + 6), at(ADDR_BYTES + 5)};
            if (len > MAX_PAYLOAD) begin
               drop(1); continue;
            end
            if (at(2) == 8'd1 && at(3) == 8'd0 && at(6) == END_MARK) begin
               drop(1); continue;
            end
            if (count < HDR_LEN + len + 2) return;
            sum = 0;
            for (int k = 0; k < HDR_LEN + len; k++) sum += at(k);
            ctrl = at(ADDR_BYTES + 4);
            if (sum[7:0] != at(HDR_LEN + len) || at(HDR_LEN + len + 1) != END_MARK
                || ctrl[7]) begin
               drop(1); continue;
            end
            for (int k = 0; k < len; k++) payload[k] = at(HDR_LEN + k);
            payload_count = len;
            r.frame_valid = 1'b1;
            r.frame_seq   = at(ADDR_BYTES + 1);
            r.func_code   = ctrl[5:0];
            r.abnormal    = ctrl[6];
            r.payload_len = len[12:0];
            drop(HDR_LEN + len + 2);
            return;
         end
      endfunction

      function void note_request(mfd_req_type q);
         mfd_rsp_type r;
         r = '0;
         case (q.cmd)
            CMD_PUSH: begin
               if (count >= RING_DEPTH) begin
                  drop(1); ovf = 1;
               end
               ring[(head + count) % RING_DEPTH] = q.rx_byte;
               count++;
               hunt(r);
            end
            CMD_POLL: hunt(r);
            CMD_READ: if (q.read_index < payload_count) r.read_data = payload[q.read_index];
            default: ;
         endcase
         r.overflow = ovf;
         pending.push_back(r);
      endfunction

      task check_response(mfd_rsp_type got);
         mfd_rsp_type w;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
            return;
         end
         w = pending.pop_front();
         if (got.frame_valid !== w.frame_valid)
            report_mismatch("frame_valid", got.frame_valid, w.frame_valid);
         if (got.frame_seq !== w.frame_seq) report_mismatch("frame_seq", got.frame_seq, w.frame_seq);
         if (got.func_code !== w.func_code) report_mismatch("func_code", got.func_code, w.func_code);
         if (got.abnormal !== w.abnormal) report_mismatch("abnormal", got.abnormal, w.abnormal);
         if (got.payload_len !== w.payload_len)
            report_mismatch("payload_len", got.payload_len, w.payload_len);
         if (got.read_data !== w.read_data) report_mismatch("read_data", got.read_data, w.read_data);
         if (got.overflow !== w.overflow) report_mismatch("overflow", got.overflow, w.overflow);
      endtask
   endclass

   deframer_board board = new();

   // Response side: random stall, check on accept
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Send one request and hold it until accepted; valid stays up between
   // back-to-back requests and drops only in idle cycles
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] b,
                               input logic [11:0] idx);
      mfd_req_type q;
      q.cmd = cmd; q.rx_byte = b; q.read_index = idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
   endtask

   task automatic push_byte(input logic [7:0] b);
      send_request(CMD_PUSH, b, 12'($urandom()));
   endtask

   // Push a well-formed frame; corrupt selects a broken variant
   task automatic push_frame(input int len, input int corrupt, input bit dir);
      logic [7:0] f[$];
      logic [7:0] sum;
      f.push_back(START_MARK);
      for (int k = 0; k < ADDR_BYTES; k++) f.push_back(8'($urandom()));
      f.push_back(8'($urandom())); f.push_back(8'($urandom()));
      f.push_back(START_MARK);
      f.push_back({dir, 7'($urandom())});
      f.push_back(len[7:0]); f.push_back(len[15:8]);
      for (int k = 0; k < len; k++) f.push_back(8'($urandom()));
      sum = 0;
      foreach (f[k]) sum += f[k];
      f.push_back(corrupt == 1 ? sum + 8'd1 : sum);
      f.push_back(corrupt == 2 ? 8'h17 : END_MARK);
      if (corrupt == 3) begin
         f[2] = 8'd1; f[3] = 8'd0; f[6] = END_MARK;
      end
      foreach (f[k]) push_byte(f[k]);
   endtask

   task automatic read_some(input int n);
      for (int k = 0; k < n; k++)
         send_request(CMD_READ, 8'($urandom()),
                      ($urandom_range(3) == 0) ? 12'($urandom()) : 12'($urandom_range(20)));
   endtask

   task automatic random_phase(input int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               push_frame($urandom_range(8), 0, 1'b0);
               sent += 20;
            end
            4: begin
               push_frame($urandom_range(6), $urandom_range(1, 3), 1'($urandom_range(1)));
               sent += 18;
            end
            5: begin
               push_byte(($urandom_range(1)) ? START_MARK : 8'($urandom()));
               sent++;
            end
            6: begin
               read_some(3); sent += 3;
            end
            7: begin
               send_request(CMD_POLL, 8'($urandom()), 12'($urandom())); sent++;
            end
            8: begin
               send_request(CMD_NOP, 8'($urandom()), 12'($urandom())); sent++;
            end
            default: begin
               for (int k = 0; k < 4; k++) push_byte(8'($urandom()));
               sent += 4;
            end
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a read before any frame, poll on empty ring, unused command
      send_request(CMD_READ, 8'hFF, 12'hFFF);
      send_request(CMD_POLL, 8'h00, 12'h000);
      send_request(CMD_NOP, 8'hFF, 12'hFFF);
      // Empty frame, bad checksum, bad end byte, odd start pattern, reply direction, good frame and reads
      push_frame(0, 0, 1'b0);
      push_frame(2, 1, 1'b0);
      push_frame(1, 2, 1'b0);
      push_frame(1, 3, 1'b0);
      push_frame(1, 0, 1'b1);
      push_frame(3, 0, 1'b0);
      send_request(CMD_READ, 8'h00, 12'd0);
      send_request(CMD_READ, 8'h00, 12'd2);
      send_request(CMD_READ, 8'h00, 12'd3);

      // Random phases with varying idle and stall pressure
      send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(150);
      send_idle_pct = 59; recv_stall_pct = 0;  random_phase(150);
      send_idle_pct = 0;  recv_stall_pct = 59; random_phase(150);
      send_idle_pct = 20; recv_stall_pct = 20; random_phase(150);
      // Long payload and one header with a length above the maximum
      send_idle_pct = 0;  recv_stall_pct = 0;
      push_frame(120, 0, 1'b0);
      read_some(4);
      push_byte(START_MARK);
      for (int k = 0; k < ADDR_BYTES + 2; k++) push_byte(8'($urandom()));
      push_byte(START_MARK);
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'h10);
      for (int k = 0; k < 20; k++) push_byte(8'($urandom()));
      send_request(CMD_POLL, 8'h00, 12'h000);
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_ram.sv
hw/rtl/mfd_dp.sv
hw/rtl/mfd_ctrl.sv
hw/rtl/meter_frame_deframer.sv
test/meter_frame_deframer_tb.sv
